/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/asm_pkg.sv */
// Shared types, widths, constants and the arctangent table of the strip and sector mapper.
package asm_pkg;

	localparam int COORD_W      = 24;
	localparam int RADIUS_W     = 24;
	localparam int SQ_W         = 2 * COORD_W;
	localparam int ANGLE_W      = 16;
	localparam int ACC_W        = 32;
	localparam int STRIP_W      = 8;
	localparam int SECTOR_W     = 6;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_W        = 24;
	localparam int CORDIC_W     = 52;
	localparam int CORDIC_SCALE = 24;
	localparam int ATAN_ENTRIES = 24;
	localparam int DIV_BITS     = STRIP_W + 1;

	localparam int DEF_NUM_STRIPS       = 24;
	localparam int DEF_NUM_SECTORS      = 8;
	localparam int DEF_ANGLE_ITERATIONS = 16;

	// Stage numbers counted in registers after the input.
	localparam int SQRT_CELLS   = RADIUS_W;
	localparam int AREA_STAGE   = 4;
	localparam int SQRT_OUT     = 3 + SQRT_CELLS;
	localparam int DIV_IN_STAGE = SQRT_OUT + 2;
	localparam int PIPE_LAST    = DIV_IN_STAGE + DIV_BITS;

	localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 2'd2;

	localparam logic [CFG_W-1:0] RST_INNER = 24'd11000;
	localparam logic [CFG_W-1:0] RST_OUTER = 24'd35000;
	localparam logic [CFG_W-1:0] RST_PITCH = 24'd1000;

	localparam logic [ACC_W-1:0] HALF_TURN  = 32'h8000_0000;
	localparam logic [ACC_W-1:0] ROUND_HALF = 32'h0000_8000;

	// Exact angles on the axes, already offset by a half turn.
	localparam logic [ANGLE_W-1:0] ANG_EAST  = 16'h8000;
	localparam logic [ANGLE_W-1:0] ANG_WEST  = 16'h0000;
	localparam logic [ANGLE_W-1:0] ANG_NORTH = 16'hC000;
	localparam logic [ANGLE_W-1:0] ANG_SOUTH = 16'h4000;

	// atan(2^-i) in units of 2^-32 turn, truncated.
	localparam logic [ACC_W-1:0] ATAN_TURN [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [CFG_W-1:0] cfg_word_t;

	typedef struct packed {
		logic [SQ_W-1:0]     rem;
		logic [RADIUS_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic [CORDIC_W-1:0] x;
		logic [CORDIC_W-1:0] y;
		logic [ACC_W-1:0]    acc;
	} cordic_t;

	typedef struct packed {
		logic                ovf;
		logic [DIV_BITS-1:0] quo;
		logic [CFG_W-1:0]    rem;
	} div_t;

	typedef struct packed {
		logic               hit;
		logic [ANGLE_W-1:0] ang;
	} spec_t;

endpackage

/* rtl/annular_strip_sector_mapper.sv */
// Annular strip and sector mapper: radius, angle, in-area flag, strip and sector of one hit.
// Throughput: one item per cycle; all stages advance together whenever the output register is free.
// The depth is set by the 24-cell square-root chain followed by the 9-cell strip divider.
// Reset clears the valid pipeline and loads inner 11000 um, outer 35000 um and pitch 1000 um.
`include "assert_macros.svh"

module annular_strip_sector_mapper #(
	parameter int NUM_STRIPS       = asm_pkg::DEF_NUM_STRIPS,
	parameter int NUM_SECTORS      = asm_pkg::DEF_NUM_SECTORS,
	parameter int ANGLE_ITERATIONS = asm_pkg::DEF_ANGLE_ITERATIONS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [asm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  asm_pkg::cfg_word_t              cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  asm_pkg::coord_t                 pos_x,
	input  asm_pkg::coord_t                 pos_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            in_area,
	output logic [asm_pkg::RADIUS_W-1:0]    radius,
	output logic [asm_pkg::ANGLE_W-1:0]     angle,
	output logic [asm_pkg::STRIP_W-1:0]     strip_index,
	output logic [asm_pkg::SECTOR_W-1:0]    sector_index
);
	import asm_pkg::*;

	localparam int T_ANG   = 3 + ANGLE_ITERATIONS;
	localparam int ANG_DLY = PIPE_LAST - T_ANG;
	localparam int IN_DLY  = PIPE_LAST - AREA_STAGE;
	localparam int R_DLY   = PIPE_LAST - SQRT_OUT;
	localparam int SECT_PROD_W = ANGLE_W + SECTOR_W + 1;
	localparam logic [STRIP_W-1:0]  LAST_STRIP  = STRIP_W'(NUM_STRIPS - 1);
	localparam logic [SECTOR_W-1:0] LAST_SECTOR = SECTOR_W'(NUM_SECTORS - 1);

	logic adv;

	// Configuration and derived limits.
	cfg_word_t       inner_q;
	cfg_word_t       outer_q;
	cfg_word_t       pitch_q;
	logic [SQ_W-1:0] lo_q;
	logic [SQ_W-1:0] hi_q;

	logic [PIPE_LAST:1] vld_q;
	logic               out_valid_q;

	// Front stages.
	coord_t               x_s1;
	coord_t               y_s1;
	logic [COORD_W-1:0]   ax_s1;
	logic [COORD_W-1:0]   ay_s1;
	logic [SQ_W-1:0]      ax2_s2;
	logic [SQ_W-1:0]      ay2_s2;
	logic [SQ_W-1:0]      sq_s3;
	logic                 in_s4;
	cordic_t              cst_s2;
	spec_t                spec_s2;

	logic signed [CORDIC_W-1:0] xe;
	logic signed [CORDIC_W-1:0] ye;
	logic signed [CORDIC_W-1:0] xp;
	logic signed [CORDIC_W-1:0] yp;
	cordic_t                    cst_nxt;
	spec_t                      spec_nxt;

	// Chains.
	sqrt_t   sq_st [SQRT_CELLS+1];
	cordic_t cs    [ANGLE_ITERATIONS+1];
	div_t    dv    [DIV_BITS+1];

	spec_t              spec_dly_q [ANGLE_ITERATIONS];
	logic [ACC_W-1:0]   acc_rnd;
	logic [ANGLE_W-1:0] ang_q;
	logic [ANGLE_W-1:0] ang_dly_q [ANG_DLY];
	logic               in_dly_q [IN_DLY];
	logic [RADIUS_W-1:0] r_dly_q [R_DLY];
	cfg_word_t          d_s28;
	div_t               div_s29;

	// Output stage.
	logic                   area_end;
	logic [ANGLE_W-1:0]     ang_end;
	div_t                   div_end;
	logic [SECT_PROD_W-1:0] sect_prod;
	logic [STRIP_W-1:0]     strip_nxt;
	logic [SECTOR_W-1:0]    sector_nxt;
	logic                   res_area_q;
	logic [RADIUS_W-1:0]    res_radius_q;
	logic [ANGLE_W-1:0]     res_angle_q;
	logic [STRIP_W-1:0]     res_strip_q;
	logic [SECTOR_W-1:0]    res_sector_q;

	// The whole pipeline moves as one whenever the output register can take a result.
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= RST_INNER;
			outer_q <= RST_OUTER;
			pitch_q <= RST_PITCH;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INNER: inner_q <= cfg_data;
				CFG_OUTER: outer_q <= cfg_data;
				CFG_PITCH: pitch_q <= (cfg_data == '0) ? CFG_W'(1) : cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= SQ_W'(inner_q) * SQ_W'(inner_q);
		hi_q <= SQ_W'(outer_q) * SQ_W'(outer_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LAST-1:1], in_valid};
			out_valid_q <= vld_q[PIPE_LAST];
		end
	end

	// Move the point into the right half plane and flag the axes, where the angle is exact.
	always_comb begin
		xe = {{(CORDIC_W - COORD_W){x_s1[COORD_W-1]}}, x_s1};
		ye = {{(CORDIC_W - COORD_W){y_s1[COORD_W-1]}}, y_s1};
		if (x_s1[COORD_W-1]) begin
			xp = -xe;
			yp = -ye;
			cst_nxt.acc = HALF_TURN;
		end else begin
			xp = xe;
			yp = ye;
			cst_nxt.acc = '0;
		end
		cst_nxt.x = xp <<< CORDIC_SCALE;
		cst_nxt.y = yp <<< CORDIC_SCALE;

		spec_nxt.hit = 1'b1;
		if (y_s1 == '0) begin
			spec_nxt.ang = x_s1[COORD_W-1] ? ANG_WEST : ANG_EAST;
		end else if (x_s1 == '0) begin
			spec_nxt.ang = y_s1[COORD_W-1] ? ANG_SOUTH : ANG_NORTH;
		end else begin
			spec_nxt.hit = 1'b0;
			spec_nxt.ang = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= pos_x;
			y_s1 <= pos_y;
			ax_s1 <= pos_x[COORD_W-1] ? COORD_W'(-pos_x) : COORD_W'(pos_x);
			ay_s1 <= pos_y[COORD_W-1] ? COORD_W'(-pos_y) : COORD_W'(pos_y);
			ax2_s2 <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			ay2_s2 <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			cst_s2 <= cst_nxt;
			spec_s2 <= spec_nxt;
			sq_s3 <= ax2_s2 + ay2_s2;
			in_s4 <= (sq_s3 >= lo_q) && (sq_s3 <= hi_q);
		end
	end

	// Square root, one result bit per cell.
	assign sq_st[0] = '{rem: sq_s3, root: '0};

	for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
		asm_sqrt_cell #(
			.BIT(SQRT_CELLS - 1 - i)
		) u_cell (
			.clk (clk),
			.en  (adv),
			.st  (sq_st[i]),
			.st_q(sq_st[i+1])
		);
	end

	// Angle, one rotation per cell.
	assign cs[0] = cst_s2;

	for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
		asm_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk (clk),
			.en  (adv),
			.st  (cs[i]),
			.st_q(cs[i+1])
		);
	end

	assign acc_rnd = cs[ANGLE_ITERATIONS].acc + HALF_TURN + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			spec_dly_q[0] <= spec_s2;
			for (int i = 1; i < ANGLE_ITERATIONS; i++) begin
				spec_dly_q[i] <= spec_dly_q[i-1];
			end
			ang_q <= spec_dly_q[ANGLE_ITERATIONS-1].hit ? spec_dly_q[ANGLE_ITERATIONS-1].ang
				: acc_rnd[ACC_W-1 -: ANGLE_W];
			ang_dly_q[0] <= ang_q;
			for (int i = 1; i < ANG_DLY; i++) begin
				ang_dly_q[i] <= ang_dly_q[i-1];
			end
			in_dly_q[0] <= in_s4;
			for (int i = 1; i < IN_DLY; i++) begin
				in_dly_q[i] <= in_dly_q[i-1];
			end
			r_dly_q[0] <= sq_st[SQRT_CELLS].root;
			for (int i = 1; i < R_DLY; i++) begin
				r_dly_q[i] <= r_dly_q[i-1];
			end
		end
	end

	// Strip divider. A quotient that needs more than DIV_BITS bits saturates anyway.
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s28 <= sq_st[SQRT_CELLS].root - inner_q;
			div_s29.rem <= d_s28;
			div_s29.quo <= '0;
			div_s29.ovf <= (SQ_W'(d_s28) >= (SQ_W'(pitch_q) << DIV_BITS));
		end
	end

	assign dv[0] = div_s29;

	for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
		asm_div_cell #(
			.BIT(DIV_BITS - 1 - i)
		) u_cell (
			.clk    (clk),
			.en     (adv),
			.divisor(pitch_q),
			.st     (dv[i]),
			.st_q   (dv[i+1])
		);
	end

	// Final stage: zero both indices outside the area, else saturate the strip and scale the angle into sectors.
	always_comb begin
		area_end = in_dly_q[IN_DLY-1];
		ang_end = ang_dly_q[ANG_DLY-1];
		div_end = dv[DIV_BITS];
		sect_prod = SECT_PROD_W'(ang_end) * SECT_PROD_W'(NUM_SECTORS);
		if (!area_end) begin
			strip_nxt = '0;
			sector_nxt = '0;
		end else begin
			if (div_end.ovf || (div_end.quo > {1'b0, LAST_STRIP})) begin
				strip_nxt = LAST_STRIP;
			end else begin
				strip_nxt = div_end.quo[STRIP_W-1:0];
			end
			sector_nxt = sect_prod[ANGLE_W +: SECTOR_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_area_q <= area_end;
			res_radius_q <= r_dly_q[R_DLY-1];
			res_angle_q <= ang_end;
			res_strip_q <= strip_nxt;
			res_sector_q <= sector_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign in_area      = res_area_q;
	assign radius       = res_radius_q;
	assign angle        = res_angle_q;
	assign strip_index  = res_strip_q;
	assign sector_index = res_sector_q;

	`ASSERT_IMP(a_outside_zero, out_valid && !in_area, strip_index == '0 && sector_index == '0, "hit outside the area carries a nonzero index")
	`ASSERT_IMP(a_strip_range, out_valid, strip_index <= LAST_STRIP, "strip index beyond the last strip")
	`ASSERT_IMP(a_sector_range, out_valid, sector_index <= LAST_SECTOR, "sector index beyond the last sector")
	`ASSERT_IMP(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "input taken while the pipeline is stalled")
	`ASSERT_NXT(a_accept_enters, in_valid && in_ready, vld_q[1], "accepted item did not enter the first stage")

endmodule

/* rtl/asm_sqrt_cell.sv */
// One cell of the square-root chain: decides one result bit and keeps the remainder.
module asm_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  asm_pkg::sqrt_t st,
	output asm_pkg::sqrt_t st_q
);
	import asm_pkg::*;

	logic [SQ_W-1:0] trial;
	sqrt_t           nxt;

	// (root + 2^BIT)^2 - root^2, with root holding only bits above BIT.
	always_comb begin
		trial = (SQ_W'(st.root) << (BIT + 1)) | (SQ_W'(1) << (2 * BIT));
		nxt = st;
		if (st.rem >= trial) begin
			nxt.rem = st.rem - trial;
			nxt.root = st.root | (RADIUS_W'(1) << BIT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

endmodule

/* rtl/asm_cordic_cell.sv */
// One vectoring rotation of the angle chain, steering y toward zero.
module asm_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  logic            en,
	input  asm_pkg::cordic_t st,
	output asm_pkg::cordic_t st_q
);
	import asm_pkg::*;

	logic signed [CORDIC_W-1:0] xc;
	logic signed [CORDIC_W-1:0] yc;
	logic signed [CORDIC_W-1:0] dx;
	logic signed [CORDIC_W-1:0] dy;
	logic                       y_pos;
	cordic_t                    nxt;

	always_comb begin
		xc = st.x;
		yc = st.y;
		dx = yc >>> STEP;
		dy = xc >>> STEP;
		y_pos = !yc[CORDIC_W-1] && (yc != '0);
		if (y_pos) begin
			nxt.x = xc + dx;
			nxt.y = yc - dy;
			nxt.acc = st.acc + ATAN_TURN[STEP];
		end else begin
			nxt.x = xc - dx;
			nxt.y = yc + dy;
			nxt.acc = st.acc - ATAN_TURN[STEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

endmodule

/* rtl/asm_div_cell.sv */
// One restoring step of the strip divider: decides one quotient bit.
module asm_div_cell #(
	parameter int BIT = 0
) (
	input  logic               clk,
	input  logic               en,
	input  asm_pkg::cfg_word_t divisor,
	input  asm_pkg::div_t      st,
	output asm_pkg::div_t      st_q
);
	import asm_pkg::*;

	localparam int SH_W = CFG_W + DIV_BITS;

	logic [SH_W-1:0] sh;
	div_t            nxt;

	// The remainder stays below twice the shifted divisor, so one compare settles the bit.
	always_comb begin
		sh = SH_W'(divisor) << BIT;
		nxt = st;
		if (SH_W'(st.rem) >= sh) begin
			nxt.rem = st.rem - sh[CFG_W-1:0];
			nxt.quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

endmodule
